/* src/call_stack_profiler_core_assert.svh */
// Assertion macros for the call stack profiler.
// Used by call_stack_profiler_core.sv; no other dependencies.
`ifndef CALL_STACK_PROFILER_CORE_ASSERT_SVH
`define CALL_STACK_PROFILER_CORE_ASSERT_SVH

// property must hold every clock outside reset
`define CSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication, consequent checked in the next cycle
`define CSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/csp_pkg.sv */
// Package for the call stack profiler: sizes, event codes, sequencer states.
// No dependencies.
package csp_pkg;
  localparam int MODULES          = 8;
  localparam int PROCS_PER_MODULE = 256;
  localparam int STACK_DEPTH      = 64;
  localparam int TIME_BITS        = 48;
  localparam int TABLE_SIZE       = MODULES * PROCS_PER_MODULE;
  localparam int SLOT_W           = $clog2(TABLE_SIZE);
  localparam int MOD_W            = $clog2(MODULES);
  localparam int PROC_W           = $clog2(PROCS_PER_MODULE);
  localparam int SP_W             = $clog2(STACK_DEPTH);
  localparam int CNT_W            = 7;
  localparam int REC_W            = 7;
  localparam int CALL_W           = 32;

  typedef enum logic [2:0] {
    K_ENTER  = 3'd0,
    K_EXIT   = 3'd1,
    K_COUNT  = 3'd2,
    K_EUSE   = 3'd3,
    K_GOTO   = 3'd4,
    K_UNWIND = 3'd5,
    K_READ   = 3'd6,
    K_NOP    = 3'd7
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_ECNT_RD,
    S_ECNT_WR,
    S_PUSH_RD,
    S_PUSH_WR,
    S_POP_RD,
    S_POP_TB,
    S_POP_WR,
    S_READ_RD,
    S_READ_WR,
    S_DONE
  } state_t;

  localparam logic [0:0] ADDR_ENABLE = 1'b0;
  localparam logic [0:0] ADDR_DEPTH  = 1'b1;
endpackage

/* src/call_stack_profiler_core.sv */
// Call stack profiler top level: stack, counter tables and sequencer.
// Depends on csp_pkg and call_stack_profiler_core_assert.svh.
//
// Usage:
//   Events arrive on the in_ channel (valid/ready). Each accepted beat gives
//   exactly one result beat on the out_ channel: counters on a read, and the
//   stack depth and profiling status after the event.
//   Configuration (enable, max depth) is written over the APB-style cfg_ port
//   by the user while the block is idle; the block itself does not enforce
//   this. pready is tied high.
// Sequencing:
//   One event at a time, driven by a sequencer around one table port: a read
//   reads the table, count and enter read then write, entry use first counts
//   the entry slot, exit/goto/unwind read and write back each popped entry,
//   ignored events and pops on an empty stack go straight to the result. The
//   next event is accepted no earlier than the edge after the result is taken.
// Reset:
//   rst_n (synchronous, active low) clears control state, then a clearing
//   pass zeroes the three tables one slot per cycle, all 2048 slots, during
//   which in_ready is low. Config writes are accepted meanwhile.
// Stall:
//   While out_valid waits for out_ready, the block holds the result and
//   accepts no new event.
module call_stack_profiler_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [2:0]  in_module_id,
  input  logic [7:0]  in_proc_index,
  input  logic [7:0]  in_entry_index,
  input  logic        in_is_paragraph,
  input  logic [47:0] in_timestamp,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_call_count,
  output logic [47:0] out_total_time,
  output logic [6:0]  out_stack_depth,
  output logic        out_profiling_active,
  output logic        out_overflowed,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import csp_pkg::*;

  // config registers
  logic       enable_r;
  logic [6:0] max_depth_r;

  // control
  state_t state_r, state_nxt;
  logic [SLOT_W-1:0] clr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              not_ovf_r;
  logic              ovf_r;

  // captured event
  kind_t              kind_r;
  logic [SLOT_W-1:0]  slot_r, eslot_r;
  logic               para_r;
  logic [TIME_BITS-1:0] ts_r;

  // stack memory
  logic [SLOT_W:0]      stk_ent_mem [STACK_DEPTH];
  logic [TIME_BITS-1:0] stk_time_mem [STACK_DEPTH];
  logic [SLOT_W:0]      stk_ent_q;
  logic [TIME_BITS-1:0] stk_time_q;

  // table memories, one shared address
  logic [CALL_W-1:0]    calls_mem [TABLE_SIZE];
  logic [REC_W-1:0]     rec_mem [TABLE_SIZE];
  logic [TIME_BITS-1:0] time_mem [TABLE_SIZE];
  logic [CALL_W-1:0]    calls_q;
  logic [REC_W-1:0]     rec_q;
  logic [TIME_BITS-1:0] time_q;

  // table port control
  logic                 tb_we;
  logic [SLOT_W-1:0]    tb_addr;
  logic [CALL_W-1:0]    tb_calls_wd;
  logic [REC_W-1:0]     tb_rec_wd;
  logic [TIME_BITS-1:0] tb_time_wd;

  // stack port control
  logic              stk_we;
  logic [SP_W-1:0]   stk_addr;

  // result register
  logic              out_valid_r;
  logic [CALL_W-1:0] res_cc_r;
  logic [47:0]       res_tt_r;

  logic [CNT_W-1:0] limit;
  logic             active;
  logic             ld_event, ld_result;
  logic [REC_W-1:0] rec_dec;
  logic [TIME_BITS-1:0] elapsed;
  logic             cfg_wr;

  assign limit  = (max_depth_r > CNT_W'(STACK_DEPTH)) ? CNT_W'(STACK_DEPTH) : max_depth_r;
  assign active = enable_r && not_ovf_r;
  assign rec_dec = rec_q - REC_W'(1);
  assign elapsed = ts_r - stk_time_q;

  assign in_ready = (state_r == S_IDLE) && !out_valid_r;
  assign ld_event = in_valid && in_ready;
  assign ld_result = (state_r == S_DONE);

  // APB
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_comb begin
    unique case (cfg_paddr[2])
      ADDR_ENABLE: cfg_prdata = {31'd0, enable_r};
      default:     cfg_prdata = {25'd0, max_depth_r};
    endcase
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      max_depth_r <= 7'd64;
    end else if (cfg_wr && cfg_paddr[1:0] == 2'b00) begin
      if (cfg_paddr[2] == ADDR_ENABLE) enable_r <= cfg_pwdata[0];
      else                             max_depth_r <= cfg_pwdata[6:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (ld_event) begin
          if (kind_t'(in_kind) == K_READ) state_nxt = S_READ_RD;
          else if (!active) state_nxt = S_DONE;
          else begin
            unique case (kind_t'(in_kind))
              K_ENTER: state_nxt = S_PUSH_RD;
              K_EUSE:  state_nxt = S_ECNT_RD;
              K_COUNT: state_nxt = S_READ_RD;
              K_EXIT, K_GOTO, K_UNWIND:
                state_nxt = (cnt_r == '0) ? S_DONE : S_POP_RD;
              default: state_nxt = S_DONE;
            endcase
          end
        end
      end
      S_CLEAR:   if (clr_r == SLOT_W'(TABLE_SIZE - 1)) state_nxt = S_IDLE;
      S_ECNT_RD: state_nxt = S_ECNT_WR;
      S_ECNT_WR: state_nxt = S_PUSH_RD;
      S_PUSH_RD: state_nxt = (cnt_r >= limit) ? S_DONE : S_PUSH_WR;
      S_PUSH_WR: state_nxt = S_DONE;
      S_POP_RD:  state_nxt = S_POP_TB;
      S_POP_TB: begin
        // goto only pops a paragraph
        if (kind_r == K_GOTO && !stk_ent_q[SLOT_W]) state_nxt = S_DONE;
        else state_nxt = S_POP_WR;
      end
      S_POP_WR: begin
        priority if (kind_r == K_GOTO) state_nxt = S_DONE;
        else if (cnt_r == '0) state_nxt = S_DONE;
        else if (kind_r == K_EXIT && stk_ent_q[SLOT_W-1:0] == slot_r) state_nxt = S_DONE;
        else state_nxt = S_POP_RD;
      end
      S_READ_RD: state_nxt = (kind_r == K_COUNT) ? S_READ_WR : S_DONE;
      S_READ_WR: state_nxt = S_DONE;
      S_DONE:    state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // table and stack port outputs
  always_comb begin
    tb_we       = 1'b0;
    tb_addr     = slot_r;
    tb_calls_wd = calls_q;
    tb_rec_wd   = rec_q;
    tb_time_wd  = time_q;
    stk_we      = 1'b0;
    stk_addr    = cnt_r[SP_W-1:0] - SP_W'(1);
    unique case (state_r)
      S_CLEAR: begin
        tb_we = 1'b1; tb_addr = clr_r;
        tb_calls_wd = '0; tb_rec_wd = '0; tb_time_wd = '0;
      end
      S_ECNT_RD: tb_addr = eslot_r;
      S_ECNT_WR: begin
        tb_we = 1'b1; tb_addr = eslot_r; tb_calls_wd = calls_q + CALL_W'(1);
      end
      S_PUSH_WR: begin
        tb_we = 1'b1;
        tb_calls_wd = calls_q + CALL_W'(1);
        tb_rec_wd = rec_q + REC_W'(1);
        stk_we = 1'b1;
        stk_addr = cnt_r[SP_W-1:0];
      end
      S_POP_TB: tb_addr = stk_ent_q[SLOT_W-1:0];
      S_POP_WR: begin
        tb_we = 1'b1;
        tb_addr = stk_ent_q[SLOT_W-1:0];
        tb_rec_wd = rec_dec;
        if (rec_dec == '0) tb_time_wd = time_q + elapsed;
      end
      S_READ_WR: begin
        tb_we = 1'b1; tb_calls_wd = calls_q + CALL_W'(1);
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (tb_we) begin
      calls_mem[tb_addr] <= tb_calls_wd;
      rec_mem[tb_addr]   <= tb_rec_wd;
      time_mem[tb_addr]  <= tb_time_wd;
    end
    calls_q <= calls_mem[tb_addr];
    rec_q   <= rec_mem[tb_addr];
    time_q  <= time_mem[tb_addr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_ent_mem[stk_addr]  <= {para_r, slot_r};
      stk_time_mem[stk_addr] <= ts_r;
    end
    stk_ent_q  <= stk_ent_mem[stk_addr];
    stk_time_q <= stk_time_mem[stk_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      not_ovf_r   <= 1'b1;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + SLOT_W'(1);
      if (ld_event) ovf_r <= 1'b0;
      if (state_r == S_PUSH_RD && cnt_r >= limit) begin
        not_ovf_r <= 1'b0;
        ovf_r     <= 1'b1;
      end
      if (state_r == S_PUSH_WR) cnt_r <= cnt_r + CNT_W'(1);
      if (state_r == S_POP_TB && !(kind_r == K_GOTO && !stk_ent_q[SLOT_W]))
        cnt_r <= cnt_r - CNT_W'(1);
      if (ld_result) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
    end
  end

  // event capture and results; read data for slot_r lands in the state after READ_RD
  always_ff @(posedge clk) begin
    if (ld_event) begin
      kind_r   <= kind_t'(in_kind);
      slot_r   <= {in_module_id[MOD_W-1:0], in_proc_index[PROC_W-1:0]};
      eslot_r  <= {in_module_id[MOD_W-1:0], in_entry_index[PROC_W-1:0]};
      para_r   <= in_is_paragraph;
      ts_r     <= in_timestamp[TIME_BITS-1:0];
      res_cc_r <= '0;
      res_tt_r <= '0;
    end
    if (state_r == S_DONE && kind_r == K_READ) begin
      res_cc_r <= calls_q;
      res_tt_r <= time_q;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_call_count       = res_cc_r;
  assign out_total_time       = res_tt_r;
  assign out_stack_depth      = cnt_r;
  assign out_profiling_active = active;
  assign out_overflowed       = ovf_r;

`include "call_stack_profiler_core_assert.svh"

  `CSP_ASSERT(a_depth_cap, cnt_r <= CNT_W'(STACK_DEPTH), "stack depth beyond capacity")
  `CSP_ASSERT(a_no_accept_busy, !(in_ready && state_r != S_IDLE), "ready while busy")
  `CSP_ASSERT_NEXT(a_ovf_sticky, !not_ovf_r, !not_ovf_r, "overflow cleared without reset")
  `CSP_ASSERT_NEXT(a_done_valid, state_r == S_DONE, out_valid_r, "result lost")
endmodule

/* verif/tb_call_stack_profiler_core.sv */
// Self-checking testbench for call_stack_profiler_core.
// Depends on csp_pkg and the RTL only; the profiler behavior is predicted in-line.
`timescale 1ns / 1ps

module tb_call_stack_profiler_core;
  import csp_pkg::*;

  typedef struct packed {
    logic [31:0] call_count;
    logic [47:0] total_time;
    logic [6:0]  stack_depth;
    logic        active;
    logic        overflowed;
  } prof_result_t;

  localparam logic [2:0] REG_ENABLE = 3'd0;   // byte address of profiling_enable
  localparam logic [2:0] REG_DEPTH  = 3'd4;   // byte address of max_stack_depth

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  kind_t       in_kind = K_NOP;
  logic [2:0]  in_module_id = '0;
  logic [7:0]  in_proc_index = '0;
  logic [7:0]  in_entry_index = '0;
  logic        in_is_paragraph = 1'b0;
  logic [47:0] in_timestamp = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_call_count;
  logic [47:0] out_total_time;
  logic [6:0]  out_stack_depth;
  logic        out_profiling_active;
  logic        out_overflowed;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  call_stack_profiler_core DUT (.*);

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Profiler shadow: stack, per-procedure tables and configuration.
  // Slot = {module, proc}, so wrapping of ids falls out of the bit widths.
  // ---------------------------------------------------------------------------
  bit          shadow_enable = 1'b0;
  bit [6:0]    shadow_max_depth = 7'd64;
  bit          shadow_alive = 1'b1;         // cleared for good by an overflow
  int          shadow_depth = 0;
  bit [10:0]   frame_slot [STACK_DEPTH];
  bit          frame_para [STACK_DEPTH];
  bit [47:0]   frame_start [STACK_DEPTH];
  bit [31:0]   calls_tab [TABLE_SIZE];
  bit [6:0]    recur_tab [TABLE_SIZE];
  bit [47:0]   time_tab [TABLE_SIZE];

  prof_result_t pending_results[$];
  int           mismatches = 0;
  bit           steady = 1'b0;              // no idling on either side while set
  logic [47:0]  now_ns = 48'd1000;

  function automatic int depth_limit();
    return (shadow_max_depth > STACK_DEPTH) ? STACK_DEPTH : int'(shadow_max_depth);
  endfunction

  function automatic bit push_frame(bit [10:0] s, bit para, bit [47:0] ts);
    if (shadow_depth >= depth_limit()) begin
      shadow_alive = 1'b0;
      return 1'b1;
    end
    frame_slot[shadow_depth]  = s;
    frame_para[shadow_depth]  = para;
    frame_start[shadow_depth] = ts;
    shadow_depth++;
    recur_tab[s] = recur_tab[s] + 7'd1;
    calls_tab[s] = calls_tab[s] + 32'd1;
    return 1'b0;
  endfunction

  // time is charged only when the outermost activation of a procedure leaves
  function automatic bit [10:0] pop_frame(bit [47:0] ts);
    bit [10:0] s;
    shadow_depth--;
    s = frame_slot[shadow_depth];
    recur_tab[s] = recur_tab[s] - 7'd1;
    if (recur_tab[s] == 7'd0)
      time_tab[s] = time_tab[s] + (ts - frame_start[shadow_depth]);
    return s;
  endfunction

  task automatic profile_event(kind_t k, bit [2:0] m, bit [7:0] p, bit [7:0] e,
                               bit para, bit [47:0] ts);
    bit [10:0]    s;
    bit [10:0]    es;
    bit [10:0]    popped;
    prof_result_t r;
    s  = {m, p};
    es = {m, e};
    r  = '0;
    if (k == K_READ) begin
      r.call_count = calls_tab[s];
      r.total_time = time_tab[s];
    end else if (shadow_enable && shadow_alive) begin
      case (k)
        K_ENTER: r.overflowed = push_frame(s, para, ts);
        K_EXIT: begin
          while (shadow_depth > 0) begin
            popped = pop_frame(ts);
            if (popped == s) break;
          end
        end
        K_COUNT: calls_tab[s] = calls_tab[s] + 32'd1;
        K_EUSE: begin
          calls_tab[es] = calls_tab[es] + 32'd1;   // kept even if the push overflows
          r.overflowed = push_frame(s, para, ts);
        end
        K_GOTO: begin
          if (shadow_depth > 0 && frame_para[shadow_depth-1]) popped = pop_frame(ts);
        end
        K_UNWIND: begin
          while (shadow_depth > 0) popped = pop_frame(ts);
        end
        default: ;
      endcase
    end
    r.stack_depth = shadow_depth[6:0];
    r.active      = shadow_enable && shadow_alive;
    pending_results.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, compare each beat with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 17);
  end

  always @(posedge clk) begin
    prof_result_t want;
    prof_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_call_count, out_total_time, out_stack_depth,
              out_profiling_active, out_overflowed};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got.call_count !== want.call_count || got.total_time !== want.total_time ||
            got.stack_depth !== want.stack_depth || got.active !== want.active ||
            got.overflowed !== want.overflowed) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Sends one event beat; valid is only lowered when a gap is taken, so it
  // never gets two assignments in one step.
  task automatic send_event(kind_t k, bit [2:0] m, bit [7:0] p, bit [7:0] e,
                            bit para, bit [47:0] ts);
    while (!steady && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= k;
    in_module_id    <= m;
    in_proc_index   <= p;
    in_entry_index  <= e;
    in_is_paragraph <= para;
    in_timestamp    <= ts;
    do @(posedge clk); while (!in_ready);
    profile_event(k, m, p, e, para, ts);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);   // the last event may still be settling
  endtask

  // ends in the cycle after the access phase so back-to-back writes never
  // assign the same strobe twice in one step
  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    if (addr == REG_ENABLE) shadow_enable = data[0];
    else shadow_max_depth = data[6:0];
  endtask

  function automatic bit [47:0] next_time();
    if ($urandom_range(49) == 0) now_ns = 48'({$urandom, $urandom});   // jumps exercise wrap
    else now_ns = now_ns + $urandom_range(1, 1000);
    return now_ns;
  endfunction

  // One random event, mostly well formed: enters and exits on a small set of
  // procedures so recursion and matching exits happen often.
  task automatic random_event();
    kind_t     k;
    int        r;
    bit [2:0]  m;
    bit [7:0]  p;
    int        idx;
    r = $urandom_range(99);
    m = $urandom_range(1) ? 3'($urandom_range(1)) : 3'($urandom);
    p = ($urandom_range(3) != 0) ? 8'($urandom_range(5)) : 8'($urandom);
    if (r < 35) k = K_ENTER;
    else if (r < 55) k = K_EXIT;
    else if (r < 62) k = K_GOTO;
    else if (r < 66) k = K_UNWIND;
    else if (r < 73) k = K_COUNT;
    else if (r < 82) k = K_EUSE;
    else if (r < 97) k = K_READ;
    else k = K_NOP;
    // keep the one overflow for the last phase
    if ((k == K_ENTER || k == K_EUSE) && shadow_depth >= depth_limit()) k = K_EXIT;
    if (k == K_EXIT && shadow_depth > 0 && $urandom_range(4) != 0) begin
      idx = $urandom_range(shadow_depth - 1);
      {m, p} = frame_slot[idx];
    end
    send_event(k, m, p, 8'($urandom), 1'($urandom), next_time());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    // disabled: everything ignored but reads
    send_event(K_ENTER, 3'd1, 8'd1, 8'd0, 1'b0, 48'd10);
    send_event(K_READ,  3'd1, 8'd1, 8'd0, 1'b0, 48'd11);
    wait_drained();
    cfg_write(REG_DEPTH, 32'd64);
    cfg_write(REG_ENABLE, 32'd1);
    send_event(K_ENTER,  3'd7, 8'd255, 8'd0,   1'b0, 48'hFFFF_FFFF_FFF0);
    send_event(K_ENTER,  3'd0, 8'd0,   8'd255, 1'b1, 48'hFFFF_FFFF_FFF8);
    send_event(K_GOTO,   3'd0, 8'd0,   8'd0,   1'b0, 48'h20);   // pops paragraph, wraps
    send_event(K_GOTO,   3'd0, 8'd0,   8'd0,   1'b0, 48'h21);   // top not a paragraph
    send_event(K_EUSE,   3'd7, 8'd255, 8'd0,   1'b1, 48'h30);   // recursion of same slot
    send_event(K_EXIT,   3'd7, 8'd255, 8'd0,   1'b0, 48'h40);   // inner activation only
    send_event(K_READ,   3'd7, 8'd255, 8'd0,   1'b0, 48'h41);
    send_event(K_EXIT,   3'd3, 8'd9,   8'd0,   1'b0, 48'h50);   // no match: pops all
    send_event(K_READ,   3'd7, 8'd255, 8'd0,   1'b0, 48'h51);
    send_event(K_EXIT,   3'd7, 8'd255, 8'd0,   1'b0, 48'h52);   // empty stack
    send_event(K_GOTO,   3'd7, 8'd255, 8'd0,   1'b0, 48'h53);
    send_event(K_UNWIND, 3'd7, 8'd255, 8'd0,   1'b0, 48'h54);
    send_event(K_COUNT,  3'd5, 8'd128, 8'd0,   1'b0, 48'h55);
    send_event(K_READ,   3'd5, 8'd128, 8'd0,   1'b0, 48'h56);
    send_event(K_READ,   3'd0, 8'd0,   8'd0,   1'b0, 48'h57);
    send_event(K_ENTER,  3'd2, 8'd3,   8'd0,   1'b1, 48'h60);
    send_event(K_ENTER,  3'd2, 8'd4,   8'd0,   1'b0, 48'h70);
    send_event(K_UNWIND, 3'd0, 8'd0,   8'd0,   1'b0, 48'h90);
    send_event(K_READ,   3'd2, 8'd3,   8'd0,   1'b0, 48'h91);
    send_event(K_NOP,    3'd6, 8'd170, 8'd85,  1'b1, 48'hAAAA_5555_AAAA);
    wait_drained();
    // smallest depth limit, filled without overflowing
    cfg_write(REG_DEPTH, 32'd1);
    send_event(K_ENTER, 3'd4, 8'd8, 8'd0, 1'b0, 48'h100);
    send_event(K_EXIT,  3'd4, 8'd8, 8'd0, 1'b0, 48'h180);
    send_event(K_READ,  3'd4, 8'd8, 8'd0, 1'b0, 48'h181);
    wait_drained();
  endtask

  task automatic test_random();
    int depths [5] = '{64, 5, 1, 40, 127};
    for (int ph = 0; ph < 5; ph++) begin
      wait_drained();
      cfg_write(REG_DEPTH, 32'(depths[ph]));
      cfg_write(REG_ENABLE, 32'(ph != 3 || 1));
      steady = (ph == 1);
      for (int i = 0; i < 220; i++) begin
        if (ph == 2 && i == 110) begin
          in_valid <= 1'b0;   // let the block run dry before carrying on
          while (pending_results.size() != 0) @(posedge clk);
        end
        if (ph == 3 && i == 60) begin
          wait_drained();
          cfg_write(REG_ENABLE, 32'd0);
        end
        if (ph == 3 && i == 100) begin
          wait_drained();
          cfg_write(REG_ENABLE, 32'd1);
        end
        random_event();
      end
    end
    steady = 1'b0;
    wait_drained();
  endtask

  // Fill to the capped limit, then one more push by an entry use shuts profiling off for good.
  task automatic test_overflow();
    cfg_write(REG_DEPTH, 32'd127);
    cfg_write(REG_ENABLE, 32'd1);
    while (shadow_depth < STACK_DEPTH)
      send_event(K_ENTER, 3'($urandom), 8'($urandom_range(3)), 8'd0, 1'($urandom),
                 next_time());
    send_event(K_EUSE, 3'd6, 8'd1, 8'd2, 1'b0, next_time());
    send_event(K_READ, 3'd6, 8'd2, 8'd0, 1'b0, next_time());
    for (int i = 0; i < 30; i++) random_event();
    wait_drained();
    cfg_write(REG_ENABLE, 32'd0);
    cfg_write(REG_ENABLE, 32'd1);
    for (int i = 0; i < 10; i++) random_event();
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random();
    test_overflow();
    repeat (50) @(posedge clk);
    if (mismatches == 0) $display("tb_call_stack_profiler_core: clean");
    else $display("tb_call_stack_profiler_core: errors");
    $finish;
  end

  initial begin
    #40000000;
    $display("tb_call_stack_profiler_core: errors");
    $finish;
  end

endmodule

/* call_stack_profiler_core.f */
+incdir+src
src/csp_pkg.sv
src/call_stack_profiler_core.sv
verif/tb_call_stack_profiler_core.sv
